@@ rtl/pfa_pkg.sv @@
// Shared types and constants for the page frame free-stack allocator.
// No dependencies; imported by pfa_ram users and the top level.
package pfa_pkg;

  localparam int POOL_PAGES = 4096;
  localparam int PAGE_W     = 44;
  localparam int IDX_W      = $clog2(POOL_PAGES);
  localparam int CNT_W      = $clog2(POOL_PAGES + 1);
  localparam int TOP_W      = PAGE_W + 1;
  localparam int CFG_IDX_W  = 2;

  localparam logic [PAGE_W-1:0] BASE_PAGE_RST = PAGE_W'(524288);

  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_START = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_END   = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RELOAD = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_DUP   = 2'd3
  } status_t;

endpackage

@@ rtl/pfa_ram.sv @@
// Generic single-write, single-read synchronous RAM; read data is registered and appears the cycle after the address.
// No dependencies; used for the free stack and the free map.
module pfa_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/page_frame_free_stack_allocator.sv @@
// Top level of the page frame free-stack allocator: command FSM, config registers.
// Depends on pfa_pkg and pfa_ram (free stack and free map memories).
//
// Usage: pulse start with in_op/in_page while busy is low. Allocate and free read
// the free stack top and the free map entry in the accepting cycle, then check,
// modify and write back in S_EXEC. busy stays high through S_EXEC after the
// accepting edge, and the result strobes on out_valid in the first cycle that busy
// is low again; a new command may be started in that same cycle. A reload walks
// every pool entry once, one entry per cycle, so busy stays high through S_EXEC,
// S_PREP and the S_SWEEP walk before the result. After reset the block is busy
// while it sweeps the free map clear. Configuration writes are taken only while
// the block is idle and start is low, so a command always sees one set of
// registers. The receiver cannot stall: out_valid is high for exactly one cycle
// per command and must be captured then.
module page_frame_free_stack_allocator
  import pfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_op,
  input  logic [PAGE_W-1:0]    in_page,
  output logic                 out_valid,
  output logic [PAGE_W-1:0]    out_granted_page,
  output logic [1:0]           out_status,
  output logic [CNT_W-1:0]     out_free_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAGE_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PREP,
    S_SWEEP
  } state_t;

  state_t            state_r, state_nxt;
  logic [PAGE_W-1:0] base_r, start_r, end_r;
  logic [CNT_W-1:0]  depth_r, depth_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [PAGE_W-1:0] lo_r, lo_nxt;
  logic [TOP_W-1:0]  hi_r, hi_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  lo_idx_r, lo_idx_nxt;
  logic [CNT_W-1:0]  hi_idx_r, hi_idx_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              rl_r, rl_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0] out_granted_r, out_granted_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;

  logic              stk_we;
  logic [IDX_W-1:0]  stk_waddr, stk_raddr, stk_wdata, stk_rdata;
  logic              bit_we;
  logic [IDX_W-1:0]  bit_waddr, bit_raddr;
  logic [0:0]        bit_wdata, bit_rdata;

  logic              accept;
  logic [PAGE_W-1:0] page_off;
  logic              out_range;
  logic [TOP_W-1:0]  pool_top;
  logic [CNT_W-1:0]  cnt_ext;

  pfa_ram #(.DEPTH(POOL_PAGES), .WIDTH(IDX_W)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  pfa_ram #(.DEPTH(POOL_PAGES), .WIDTH(1)) u_fmap (
    .clk   (clk),
    .we    (bit_we),
    .waddr (bit_waddr),
    .wdata (bit_wdata),
    .raddr (bit_raddr),
    .rdata (bit_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  // Hold register writes off while a command is being taken or executed.
  assign cfg_ready = !busy && !start;

  // Reads are issued in the accept cycle so data lands in S_EXEC.
  assign stk_raddr = IDX_W'(depth_r - CNT_W'(1));
  assign bit_raddr = in_page[IDX_W-1:0] - base_r[IDX_W-1:0];

  assign page_off  = page_r - base_r;
  assign out_range = (page_r < start_r) || (page_r >= end_r) || (page_r < base_r) ||
                     (page_off[PAGE_W-1:IDX_W] != '0);
  assign pool_top  = {1'b0, base_r} + TOP_W'(POOL_PAGES);
  assign cnt_ext   = {{(CNT_W-IDX_W){1'b0}}, cnt_r};

  always_comb begin
    state_nxt       = state_r;
    depth_nxt       = depth_r;
    op_nxt          = op_r;
    page_nxt        = page_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    n_nxt           = n_r;
    lo_idx_nxt      = lo_idx_r;
    hi_idx_nxt      = hi_idx_r;
    cnt_nxt         = cnt_r;
    rl_nxt          = rl_r;
    out_valid_nxt   = 1'b0;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;

    stk_we    = 1'b0;
    stk_waddr = depth_r[IDX_W-1:0];
    stk_wdata = page_off[IDX_W-1:0];
    bit_we    = 1'b0;
    bit_waddr = page_off[IDX_W-1:0];
    bit_wdata = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_op;
          page_nxt  = in_page;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        out_granted_nxt = '0;
        out_status_nxt  = ST_OK;
        out_valid_nxt   = 1'b1;
        state_nxt       = S_IDLE;
        case (op_t'(op_r))
          OP_ALLOC: begin
            if (depth_r == '0) begin
              out_status_nxt = ST_EMPTY;
            end else begin
              depth_nxt       = depth_r - CNT_W'(1);
              bit_we          = 1'b1;
              bit_waddr       = stk_rdata;
              bit_wdata       = 1'b0;
              out_granted_nxt = base_r + PAGE_W'(stk_rdata);
            end
          end
          OP_FREE: begin
            if (out_range) begin
              out_status_nxt = ST_RANGE;
            end else if (bit_rdata[0]) begin
              out_status_nxt = ST_DUP;
            end else if (depth_r != CNT_W'(POOL_PAGES)) begin
              stk_we    = 1'b1;
              bit_we    = 1'b1;
              depth_nxt = depth_r + CNT_W'(1);
            end
          end
          OP_RELOAD: begin
            // Clamp the range to the pool window, then walk it.
            lo_nxt        = (start_r < base_r) ? base_r : start_r;
            hi_nxt        = ({1'b0, end_r} > pool_top) ? pool_top : {1'b0, end_r};
            rl_nxt        = 1'b1;
            out_valid_nxt = 1'b0;
            state_nxt     = S_PREP;
          end
          default: ;
        endcase
        out_count_nxt = depth_nxt;
      end

      S_PREP: begin
        if (hi_r > {1'b0, lo_r}) begin
          n_nxt      = CNT_W'(hi_r - {1'b0, lo_r});
          hi_idx_nxt = CNT_W'(hi_r - {1'b0, base_r});
          lo_idx_nxt = CNT_W'(lo_r - base_r);
        end else begin
          n_nxt      = '0;
          hi_idx_nxt = '0;
          lo_idx_nxt = '0;
        end
        cnt_nxt   = '0;
        state_nxt = S_SWEEP;
      end

      S_SWEEP: begin
        // Rewrite one map entry and one stack slot per cycle; lowest page ends on top.
        bit_we    = 1'b1;
        bit_waddr = cnt_r;
        bit_wdata = (cnt_ext >= lo_idx_r) && (cnt_ext < hi_idx_r);
        stk_we    = 1'b1;
        stk_waddr = cnt_r;
        stk_wdata = IDX_W'(hi_idx_r - CNT_W'(1) - cnt_ext);
        cnt_nxt   = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(POOL_PAGES - 1)) begin
          state_nxt       = S_IDLE;
          depth_nxt       = n_r;
          rl_nxt          = 1'b0;
          out_valid_nxt   = rl_r;
          out_granted_nxt = '0;
          out_status_nxt  = ST_OK;
          out_count_nxt   = n_r;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // Reset runs a sweep with an empty range to clear the free map.
      state_r     <= S_SWEEP;
      depth_r     <= '0;
      cnt_r       <= '0;
      n_r         <= '0;
      lo_idx_r    <= '0;
      hi_idx_r    <= '0;
      rl_r        <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= BASE_PAGE_RST;
      start_r     <= '0;
      end_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      lo_idx_r    <= lo_idx_nxt;
      hi_idx_r    <= hi_idx_nxt;
      rl_r        <= rl_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE:  base_r  <= cfg_data;
          CFG_START: start_r <= cfg_data;
          CFG_END:   end_r   <= cfg_data;
          default: ;
        endcase
      end
    end
    op_r          <= op_nxt;
    page_r        <= page_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_granted_page = out_granted_r;
  assign out_status       = out_status_r;
  assign out_free_count   = out_count_r;

`ifndef SYNTHESIS
  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_short_cmd_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op != OP_RELOAD) |-> ##2 out_valid)
    else $error("allocate/free result missing two cycles after accept");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_free_count <= CNT_W'(POOL_PAGES)))
    else $error("free count exceeds pool size");

  a_empty_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_free_count == '0 &&
                                               out_granted_page == '0))
    else $error("empty status with nonzero count or grant");
`endif

endmodule

@@ tb/sv/page_frame_alloc_monitor.sv @@
// Monitor for the page frame allocator testbench: mirrors the free stack and free map,
// predicts the result of every accepted command and compares it with the result strobe.
// Depends on pfa_pkg for widths, opcodes, status codes and register indexes.
`timescale 1ns / 100ps

module page_frame_alloc_monitor
  import pfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           in_op,
  input  logic [PAGE_W-1:0]    in_page,
  input  logic                 out_valid,
  input  logic [PAGE_W-1:0]    out_granted_page,
  input  logic [1:0]           out_status,
  input  logic [CNT_W-1:0]     out_free_count,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAGE_W-1:0]    cfg_data,
  output int                   mismatch_count,
  output int                   results_owed
);

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    status_t           status;
    logic [CNT_W-1:0]  count;
  } page_result_t;

  logic [PAGE_W-1:0]     base_reg;
  logic [PAGE_W-1:0]     start_reg;
  logic [PAGE_W-1:0]     end_reg;
  logic [IDX_W-1:0]      frame_stack [POOL_PAGES];
  logic [POOL_PAGES-1:0] frame_bits;
  int                    stack_depth;
  page_result_t          expected_results [$];

  function automatic void push_frame(input logic [IDX_W-1:0] idx);
    if (stack_depth < POOL_PAGES) begin
      frame_stack[stack_depth] = idx;
      stack_depth++;
      frame_bits[idx] = 1'b1;
    end
  endfunction

  function automatic page_result_t predict_page_op(input logic [1:0] op,
                                                   input logic [PAGE_W-1:0] pg);
    page_result_t     r;
    logic [TOP_W-1:0] lo;
    logic [TOP_W-1:0] hi;
    logic [TOP_W-1:0] top_page;
    logic [TOP_W-1:0] v;
    logic [IDX_W-1:0] idx;
    r.page   = '0;
    r.status = ST_OK;
    case (op)
      OP_ALLOC: begin
        if (stack_depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          stack_depth--;
          idx = frame_stack[stack_depth];
          frame_bits[idx] = 1'b0;
          // uses the current base, so it wraps when that base plus the index overflows
          r.page = base_reg + PAGE_W'(idx);
        end
      end
      OP_FREE: begin
        if (pg < start_reg || pg >= end_reg || pg < base_reg ||
            (pg - base_reg) >= PAGE_W'(POOL_PAGES)) begin
          r.status = ST_RANGE;
        end else begin
          idx = IDX_W'(pg - base_reg);
          if (frame_bits[idx]) r.status = ST_DUP;
          else push_frame(idx);
        end
      end
      OP_RELOAD: begin
        frame_bits  = '0;
        stack_depth = 0;
        lo       = (start_reg < base_reg) ? {1'b0, base_reg} : {1'b0, start_reg};
        top_page = {1'b0, base_reg} + TOP_W'(POOL_PAGES);
        hi       = ({1'b0, end_reg} > top_page) ? top_page : {1'b0, end_reg};
        // push highest first so the lowest page lands on top
        for (v = hi; v > lo; v--) push_frame(IDX_W'(v - 1'b1 - {1'b0, base_reg}));
      end
      default: ;
    endcase
    r.count = CNT_W'(stack_depth);
    return r;
  endfunction

  always @(posedge clk) begin
    page_result_t exp_r;
    int           bad;
    bad = 0;
    if (!rst_n) begin
      base_reg    = BASE_PAGE_RST;
      start_reg   = '0;
      end_reg     = '0;
      frame_bits  = '0;
      stack_depth = 0;
      expected_results.delete();
      mismatch_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE:  base_reg  = cfg_data;
          CFG_START: start_reg = cfg_data;
          CFG_END:   end_reg   = cfg_data;
          default: ;
        endcase
      end
      // results at this edge belong to commands accepted earlier
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual page %h status %0d count %0d",
                   $time, out_granted_page, out_status, out_free_count);
          bad++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_granted_page !== exp_r.page) begin
            $display("%0t: granted_page expected %h actual %h",
                     $time, exp_r.page, out_granted_page);
            bad++;
          end
          if (out_status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_status);
            bad++;
          end
          if (out_free_count !== exp_r.count) begin
            $display("%0t: free_count expected %0d actual %0d",
                     $time, exp_r.count, out_free_count);
            bad++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(predict_page_op(in_op, in_page));
      mismatch_count <= mismatch_count + bad;
    end
    results_owed <= expected_results.size();
  end

endmodule

@@ tb/sv/page_frame_free_stack_allocator_tb.sv @@
// Top of the page frame allocator testbench: clock, reset, register writes and commands.
// Depends on pfa_pkg, the allocator RTL and page_frame_alloc_monitor for all checking.
`timescale 1ns / 100ps

module page_frame_free_stack_allocator_tb;
  import pfa_pkg::*;

  localparam logic [1:0]           OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
  localparam logic [PAGE_W-1:0]    PAGE_MAX  = {PAGE_W{1'b1}};

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_op;
  logic [PAGE_W-1:0]    in_page;
  logic                 out_valid;
  logic [PAGE_W-1:0]    out_granted_page;
  logic [1:0]           out_status;
  logic [CNT_W-1:0]     out_free_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAGE_W-1:0]    cfg_data;
  int                   mismatch_count;
  int                   results_owed;
  int                   idle_pct;

  always #1 clk = ~clk;

  page_frame_free_stack_allocator DUT (
    .clk, .rst_n, .start, .busy, .in_op, .in_page,
    .out_valid, .out_granted_page, .out_status, .out_free_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  page_frame_alloc_monitor monitor (
    .clk, .rst_n, .start, .busy, .in_op, .in_page,
    .out_valid, .out_granted_page, .out_status, .out_free_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatch_count, .results_owed
  );

  // Hold the command until accepted, then maybe drop start and idle before returning.
  task automatic run_command(input logic [1:0] op, input logic [PAGE_W-1:0] pg);
    start   <= 1'b1;
    in_op   <= op;
    in_page <= pg;
    do @(posedge clk); while (busy);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic put_register(input logic [CFG_IDX_W-1:0] idx, input logic [PAGE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_registers(input logic [PAGE_W-1:0] b, s, e);
    put_register(CFG_BASE, b);
    put_register(CFG_START, s);
    put_register(CFG_END, e);
    cfg_valid <= 1'b0;
  endtask

  // Drop start and wait until every transaction has produced its result.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_command(input logic [PAGE_W-1:0] lo, input int span);
    int                pick;
    logic [PAGE_W-1:0] pg;
    pick = $urandom_range(0, 99);
    pg   = PAGE_W'({$urandom(), $urandom()});
    if (pick < 45) begin
      run_command(OP_ALLOC, pg);
    end else if (pick < 94) begin
      // mostly pages around the managed range, the rest anywhere
      if ($urandom_range(0, 4) != 0) pg = lo + PAGE_W'($urandom_range(0, span + 3)) - PAGE_W'(2);
      run_command(OP_FREE, pg);
    end else if (pick < 98) begin
      run_command(OP_UNUSED, pg);
    end else begin
      run_command(OP_RELOAD, pg);
    end
  endtask

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int                sel;
    int                span;
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] lo;
    logic [PAGE_W-1:0] hi;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_op     <= OP_ALLOC;
    in_page   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BASE;
    cfg_data  <= '0;
    idle_pct  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // small range whose start lies below the base, so a reload clamps it
    write_registers(BASE_PAGE_RST, BASE_PAGE_RST - PAGE_W'(16), BASE_PAGE_RST + PAGE_W'(4));
    run_command(OP_ALLOC, '0);
    run_command(OP_UNUSED, PAGE_MAX);
    run_command(OP_FREE, BASE_PAGE_RST + PAGE_W'(2));
    run_command(OP_FREE, BASE_PAGE_RST + PAGE_W'(2));
    run_command(OP_RELOAD, '0);
    run_command(OP_ALLOC, '0);
    run_command(OP_FREE, BASE_PAGE_RST);
    run_command(OP_FREE, BASE_PAGE_RST - PAGE_W'(1));
    run_command(OP_FREE, BASE_PAGE_RST + PAGE_W'(4));
    run_command(OP_FREE, PAGE_MAX);
    repeat (5) run_command(OP_ALLOC, '0);
    settle();

    // whole pool, end clamped to base plus pool size
    write_registers('0, '0, PAGE_MAX);
    run_command(OP_RELOAD, '0);
    run_command(OP_ALLOC, '0);
    run_command(OP_FREE, '0);
    run_command(OP_FREE, PAGE_W'(POOL_PAGES));
    settle();

    // move the base to the top without reloading: granted pages wrap
    put_register(CFG_BASE, PAGE_MAX);
    put_register(CFG_SPARE, PAGE_W'({$urandom(), $urandom()}));
    cfg_valid <= 1'b0;
    repeat (3) run_command(OP_ALLOC, '0);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 48 : 32;
      sel = $urandom_range(0, 9);
      if (sel < 3) base = PAGE_W'({$urandom(), $urandom()});
      else if (sel < 5) base = PAGE_MAX - PAGE_W'($urandom_range(0, 5000));
      else base = PAGE_W'($urandom_range(0, 1 << 20));
      span = (sel == 9) ? $urandom_range(1000, 4200) : $urandom_range(1, 40);
      lo   = base + PAGE_W'($urandom_range(0, 6)) - PAGE_W'(3);
      hi   = ($urandom_range(0, 9) == 0) ? lo - PAGE_W'(1) : lo + PAGE_W'(span);
      write_registers(base, lo, hi);
      // now and then keep the old pool under the new registers
      if ($urandom_range(0, 3) != 0) run_command(OP_RELOAD, '0);
      repeat (120) random_command(lo, span);
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
